### sv/lmrs_pkg.sv
// shared types for the lane midline row scan block
package lmrs_pkg;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        frame_end;
  } in_t;

  typedef struct packed {
    logic [5:0] row_index;
    logic [6:0] centre_col;
    logic       left_found;
    logic [6:0] left_col;
    logic       right_found;
    logic [6:0] right_col;
    logic       filled;
    logic       end_hit;
    logic [6:0] fill_total;
    logic       last;
  } out_t;

  // flags of the shared window compare unit
  typedef struct packed {
    logic pix_c;
    logic hit_left;
    logic hit_right;
  } edge_t;

endpackage

### sv/lmrs_ram.sv
// generic single write port, single read port ram with registered read
module lmrs_ram #(
  parameter int DW    = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/lmrs_edge.sv
// three pixel window compare unit shared by centre check and both edge searches
module lmrs_edge import lmrs_pkg::*; #(
  parameter int WIDTH = 128
) (
  input  logic [WIDTH-1:0]         row_pix,
  input  logic [$clog2(WIDTH)-1:0] x,
  input  logic                     upper,
  output edge_t                    flags
);

  localparam int CW = $clog2(WIDTH);

  logic p_c;
  logic p_l;
  logic p_r;

  always_comb begin
    p_c = row_pix[x];
    // neighbors outside the row read as black
    p_l = (x == '0) ? 1'b0 : row_pix[x - CW'(1)];
    p_r = (x == CW'(WIDTH - 1)) ? 1'b0 : row_pix[x + CW'(1)];
    flags.pix_c     = p_c;
    flags.hit_left  = p_c & ~p_r & (p_l | upper);
    flags.hit_right = p_c & ~p_l & (p_r | upper);
  end

endmodule

### sv/lane_midline_row_scan_top.sv
// top level of the lane midline row scan block: frame load and row scan sequencer
//
// Usage: a binary frame is written in raster order, one pixel word per transfer
// on in_item while start is high and busy is low. Bit i of a word is column
// base+i. The transfer flagged frame_end stores its word and starts the row
// scan; busy then stays high until the last row result has been issued.
// Rows are scanned bottom row first. For each row the sequencer fetches the
// row from the frame store, checks the centre pixel, steps the shared window
// unit column by column in the left search and then in the right search,
// and updates the centre. The edge search loop sets the rate. Rows run from
// HEIGHT-1 up to HEIGHT/6; a white centre pixel ends the scan early. Each
// result is shown for one cycle with out_valid high; the receiver cannot
// stall, so results are never held. Reset returns the sequencer to idle and
// the write address to zero; the frame store keeps no reset value and must
// be loaded before a scan.
module lane_midline_row_scan_top import lmrs_pkg::*; #(
  parameter int WIDTH       = 128,
  parameter int HEIGHT      = 64,
  parameter int WORD_PIXELS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  localparam int RW   = (WIDTH + WORD_PIXELS - 1) / WORD_PIXELS;
  localparam int FW   = RW * HEIGHT;
  localparam int AW   = $clog2(FW);
  localparam int CW   = $clog2(WIDTH);
  localparam int YW   = $clog2(HEIGHT);
  localparam int WCW  = $clog2(RW + 1);
  localparam int RBW  = RW * WORD_PIXELS;
  localparam int STOP = HEIGHT / 6;
  localparam int HALF = HEIGHT / 2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_CHECK = 6'b000100,
    S_LEFT  = 6'b001000,
    S_RIGHT = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   wc_r, wc_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [WCW-1:0]  w_r, w_nxt;
  logic [YW-1:0]   y_r, y_nxt;
  logic [CW-1:0]   x_r, x_nxt;
  logic [CW-1:0]   centre_r, centre_nxt;
  logic [6:0]      fill_r, fill_nxt;
  logic            lf_r, lf_nxt;
  logic [CW-1:0]   lcol_r, lcol_nxt;
  logic            rf_r, rf_nxt;
  logic [CW-1:0]   rcol_r, rcol_nxt;
  logic [RBW-1:0]  rowbuf_r, rowbuf_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_r, out_nxt;

  logic                we;
  logic [AW-1:0]       raddr;
  logic [31:0]         rdata;
  logic [63:0]         rdata64;
  logic [WIDTH-1:0]    row_pix;
  logic                bottom;
  logic                upper;
  edge_t               flags;
  logic [CW:0]         sum;

  assign we    = start & ~busy;
  assign raddr = base_r + AW'(w_r);

  lmrs_ram #(
    .DW    (32),
    .DEPTH (FW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wc_r),
    .wdata (in_item.pixel_word),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign bottom  = (y_r == YW'(HEIGHT - 1));
  assign upper   = (y_r < YW'(HALF));
  assign rdata64 = 64'(rdata);

  // bottom row reads black except the two outer columns at each side
  always_comb begin
    for (int i = 0; i < WIDTH; i++) begin
      row_pix[i] = rowbuf_r[i] & (~bottom | (i < 2) | (i >= WIDTH - 2));
    end
  end

  lmrs_edge #(
    .WIDTH (WIDTH)
  ) u_edge (
    .row_pix (row_pix),
    .x       (x_r),
    .upper   (upper),
    .flags   (flags)
  );

  always_comb begin
    state_nxt     = state_r;
    wc_nxt        = wc_r;
    base_nxt      = base_r;
    w_nxt         = w_r;
    y_nxt         = y_r;
    x_nxt         = x_r;
    centre_nxt    = centre_r;
    fill_nxt      = fill_r;
    lf_nxt        = lf_r;
    lcol_nxt      = lcol_r;
    rf_nxt        = rf_r;
    rcol_nxt      = rcol_r;
    rowbuf_nxt    = rowbuf_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    sum           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (we) begin
          if (in_item.frame_end) begin
            wc_nxt     = '0;
            centre_nxt = CW'(WIDTH / 2);
            fill_nxt   = '0;
            y_nxt      = YW'(HEIGHT - 1);
            base_nxt   = AW'((HEIGHT - 1) * RW);
            w_nxt      = '0;
            state_nxt  = S_FETCH;
          end else begin
            wc_nxt = (wc_r == AW'(FW - 1)) ? '0 : wc_r + AW'(1);
          end
        end
      end

      S_FETCH: begin
        // read data is registered and belongs to the previous address; words shift in from the top
        if (w_r != '0) begin
          rowbuf_nxt = rowbuf_r >> WORD_PIXELS;
          rowbuf_nxt[RBW-1 -: WORD_PIXELS] = rdata64[WORD_PIXELS-1:0];
        end
        w_nxt = w_r + WCW'(1);
        if (w_r == WCW'(RW)) begin
          x_nxt     = centre_r;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (flags.pix_c) begin
          out_valid_nxt        = 1'b1;
          out_nxt.row_index    = 6'(y_r);
          out_nxt.centre_col   = 7'(centre_r);
          out_nxt.left_found   = 1'b0;
          out_nxt.left_col     = '0;
          out_nxt.right_found  = 1'b0;
          out_nxt.right_col    = '0;
          out_nxt.filled       = 1'b0;
          out_nxt.end_hit      = 1'b1;
          out_nxt.fill_total   = fill_r;
          out_nxt.last         = 1'b1;
          state_nxt            = S_IDLE;
        end else begin
          lf_nxt    = 1'b0;
          rf_nxt    = 1'b0;
          lcol_nxt  = '0;
          rcol_nxt  = '0;
          state_nxt = S_LEFT;
        end
      end

      S_LEFT: begin
        if (x_r == '0) begin
          x_nxt     = centre_r;
          state_nxt = S_RIGHT;
        end else if (x_r <= CW'(WIDTH - 2) && flags.hit_left) begin
          lf_nxt    = 1'b1;
          lcol_nxt  = x_r;
          x_nxt     = centre_r;
          state_nxt = S_RIGHT;
        end else begin
          x_nxt = x_r - CW'(1);
        end
      end

      S_RIGHT: begin
        if (x_r > CW'(WIDTH - 2)) begin
          state_nxt = S_EMIT;
        end else if (x_r != '0 && flags.hit_right) begin
          rf_nxt    = 1'b1;
          rcol_nxt  = x_r;
          state_nxt = S_EMIT;
        end else begin
          x_nxt = x_r + CW'(1);
        end
      end

      S_EMIT: begin
        priority if (lf_r && rf_r) begin
          sum = {1'b0, lcol_r} + {1'b0, rcol_r};
        end else if (rf_r) begin
          sum = {1'b0, rcol_r} + (CW + 1)'(1);
        end else if (lf_r) begin
          sum = {1'b0, lcol_r} + (CW + 1)'(WIDTH - 2);
        end else begin
          sum = (CW + 1)'(WIDTH - 1);
        end
        centre_nxt = sum[CW:1];
        if (!lf_r && !rf_r) begin
          fill_nxt = fill_r + 7'd1;
        end
        out_valid_nxt        = 1'b1;
        out_nxt.row_index    = 6'(y_r);
        out_nxt.centre_col   = 7'(sum[CW:1]);
        out_nxt.left_found   = lf_r;
        out_nxt.left_col     = 7'(lcol_r);
        out_nxt.right_found  = rf_r;
        out_nxt.right_col    = 7'(rcol_r);
        out_nxt.filled       = ~lf_r & ~rf_r;
        out_nxt.end_hit      = 1'b0;
        out_nxt.fill_total   = (!lf_r && !rf_r) ? fill_r + 7'd1 : fill_r;
        out_nxt.last         = (y_r == YW'(STOP));
        if (y_r == YW'(STOP)) begin
          state_nxt = S_IDLE;
        end else begin
          y_nxt     = y_r - YW'(1);
          base_nxt  = base_r - AW'(RW);
          w_nxt     = '0;
          state_nxt = S_FETCH;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wc_r        <= wc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    w_r      <= w_nxt;
    y_r      <= y_nxt;
    x_r      <= x_nxt;
    centre_r <= centre_nxt;
    fill_r   <= fill_nxt;
    lf_r     <= lf_nxt;
    lcol_r   <= lcol_nxt;
    rf_r     <= rf_nxt;
    rcol_r   <= rcol_nxt;
    rowbuf_r <= rowbuf_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### sim/tb_top.sv
// self-checking testbench for the lane midline row scan block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lmrs_pkg::*;

  localparam int IMG_W         = 128;
  localparam int IMG_H         = 64;
  localparam int WORD_PX       = 32;
  localparam int ROW_WORDS     = IMG_W / WORD_PX;
  localparam int FRAME_WORDS   = ROW_WORDS * IMG_H;
  localparam int TOP_ROW       = IMG_H / 6;
  localparam int WATCH_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_REPORTS   = 10;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;

  // shadow of the frame store and the scan state
  logic [31:0] frame_mem [FRAME_WORDS];
  int          wr_addr;
  out_t        expected_rows [$];
  out_t        want_row;

  // image being loaded, one 128-bit vector per row
  logic [IMG_W-1:0] pic [IMG_H];

  bit gaps_on;
  int quiet_cycles;
  int mismatches;
  int words_sent;
  int frames_sent;
  int rows_predicted;
  int rows_checked;
  int fills_seen;
  int end_hits_seen;

  lane_midline_row_scan_top #(
    .WIDTH(IMG_W),
    .HEIGHT(IMG_H),
    .WORD_PIXELS(WORD_PX)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit px(int y, int x);
    if (x < 0 || x >= IMG_W || y < 0 || y >= IMG_H) return 1'b0;
    // bottom row is read as black apart from the two outer columns per side
    if (y == IMG_H - 1 && x >= 2 && x < IMG_W - 2) return 1'b0;
    return frame_mem[y * ROW_WORDS + x / WORD_PX][x % WORD_PX];
  endfunction

  function automatic void predict_transfer(in_t w);
    int   centre;
    int   fills;
    int   lcol;
    int   rcol;
    int   x;
    int   y;
    bit   upper;
    bit   stop;
    out_t r;
    frame_mem[wr_addr] = w.pixel_word;
    wr_addr = (wr_addr + 1) % FRAME_WORDS;
    if (!w.frame_end) return;
    wr_addr = 0;
    centre = IMG_W / 2;
    fills = 0;
    stop = 1'b0;
    for (y = IMG_H - 1; y >= TOP_ROW && !stop; y--) begin
      r = '0;
      r.row_index = 6'(y);
      if (px(y, centre)) begin
        r.centre_col = 7'(centre);
        r.end_hit = 1'b1;
        r.fill_total = 7'(fills);
        r.last = 1'b1;
        stop = 1'b1;
      end else begin
        upper = (y < IMG_H / 2);
        lcol = -1;
        for (x = centre; x >= 1 && lcol < 0; x--)
          if (x <= IMG_W - 2 && px(y, x) && !px(y, x + 1) && (px(y, x - 1) || upper))
            lcol = x;
        rcol = -1;
        for (x = centre; x <= IMG_W - 2 && rcol < 0; x++)
          if (x >= 1 && px(y, x) && !px(y, x - 1) && (px(y, x + 1) || upper))
            rcol = x;
        if (lcol >= 0 && rcol >= 0) centre = (lcol + rcol) / 2;
        else if (rcol >= 0) centre = (rcol + 1) / 2;
        else if (lcol >= 0) centre = (lcol + IMG_W - 2) / 2;
        else begin
          centre = (IMG_W - 1) / 2;
          fills++;
          r.filled = 1'b1;
        end
        r.centre_col = 7'(centre);
        r.left_found = (lcol >= 0);
        r.left_col = (lcol >= 0) ? 7'(lcol) : 7'd0;
        r.right_found = (rcol >= 0);
        r.right_col = (rcol >= 0) ? 7'(rcol) : 7'd0;
        r.fill_total = 7'(fills);
        r.last = (y == TOP_ROW);
      end
      expected_rows.push_back(r);
      rows_predicted++;
    end
  endfunction

  function automatic string row_text(out_t r);
    return {$sformatf("row=%0d centre=%0d L=%0b/%0d R=%0b/%0d ", r.row_index, r.centre_col,
                      r.left_found, r.left_col, r.right_found, r.right_col),
            $sformatf("fill=%0b end=%0b total=%0d last=%0b", r.filled, r.end_hit,
                      r.fill_total, r.last)};
  endfunction

  task automatic report_mismatch(string what, out_t want, out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: expected %s, got %s", $realtime, what, row_text(want), row_text(got));
  endtask

  // results cannot be stalled, so every strobe is a transfer
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      rows_checked++;
      fills_seen += out_item.filled;
      end_hits_seen += out_item.end_hit;
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected row result", '0, out_item);
      end else begin
        want_row = expected_rows.pop_front();
        if (out_item.row_index   !== want_row.row_index   ||
            out_item.centre_col  !== want_row.centre_col  ||
            out_item.left_found  !== want_row.left_found  ||
            out_item.left_col    !== want_row.left_col    ||
            out_item.right_found !== want_row.right_found ||
            out_item.right_col   !== want_row.right_col   ||
            out_item.filled      !== want_row.filled      ||
            out_item.end_hit     !== want_row.end_hit     ||
            out_item.fill_total  !== want_row.fill_total  ||
            out_item.last        !== want_row.last)
          report_mismatch("row result mismatch", want_row, out_item);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results pending",
                 WATCH_LIMIT, expected_rows.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one word transfer; an optional gap drops start right after the previous transfer
  task automatic send_word(logic [31:0] word, bit last_word);
    in_t w;
    if (gaps_on && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    w.pixel_word = word;
    w.frame_end = last_word;
    start <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_transfer(w);
    words_sent++;
  endtask

  task automatic load_frame(int n_words);
    int i;
    for (i = 0; i < n_words; i++)
      send_word(pic[(i / ROW_WORDS) % IMG_H][(i % ROW_WORDS) * WORD_PX +: WORD_PX],
                i == n_words - 1);
    frames_sent++;
  endtask

  // two drifting lane lines, lines face the centre with their inner pixel
  task automatic draw_lane(int thick_max, int miss_pct, int noise_pct);
    int l;
    int r;
    int y;
    int k;
    int th;
    int spot;
    l = $urandom_range(6, 50);
    r = $urandom_range(77, 121);
    for (y = 0; y < IMG_H; y++) begin
      pic[y] = '0;
      l = l + int'($urandom_range(0, 4)) - 2;
      r = r + int'($urandom_range(0, 4)) - 2;
      if (l < 4) l = 4;
      if (l > 56) l = 56;
      if (r < 70) r = 70;
      if (r > 123) r = 123;
      th = $urandom_range(1, thick_max);
      if ($urandom_range(0, 99) >= miss_pct)
        for (k = 0; k < th; k++) pic[y][l - k] = 1'b1;
      th = $urandom_range(1, thick_max);
      if ($urandom_range(0, 99) >= miss_pct)
        for (k = 0; k < th; k++) pic[y][r + k] = 1'b1;
      if ($urandom_range(0, 99) < noise_pct) begin
        spot = $urandom_range(0, IMG_W - 1);
        pic[y][spot] = 1'b1;
      end
    end
    pic[IMG_H-1][1:0] = 2'($urandom);
    pic[IMG_H-1][IMG_W-1 -: 2] = 2'($urandom);
  endtask

  task automatic test_lane_frame();
    gaps_on = 1'b0;
    draw_lane(3, 10, 0);
    // only the outer columns of a white bottom row count
    pic[IMG_H-1] = '1;
    load_frame(FRAME_WORDS);
  endtask

  task automatic test_word_extremes();
    gaps_on = 1'b1;
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    frames_sent++;
  endtask

  task automatic test_blank_frame();
    int y;
    for (y = 0; y < IMG_H; y++) pic[y] = '0;
    load_frame(FRAME_WORDS);
  endtask

  task automatic test_end_hit();
    draw_lane(3, 0, 0);
    pic[40] = '1;
    load_frame(FRAME_WORDS);
  endtask

  task automatic test_early_frame_end();
    draw_lane(2, 20, 10);
    load_frame(3 * ROW_WORDS);
  endtask

  task automatic test_overlong_frame();
    draw_lane(3, 10, 10);
    load_frame(FRAME_WORDS + 2 * ROW_WORDS);
  endtask

  task automatic test_random_frames();
    int first_word;
    int first_row;
    int n_frames;
    int kind;
    int y;
    int w;
    first_word = words_sent;
    first_row = rows_predicted;
    n_frames = 0;
    while (words_sent - first_word < 180 || rows_predicted - first_row < 60 || n_frames < 4) begin
      gaps_on = (n_frames == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        for (y = 0; y < IMG_H; y++)
          for (w = 0; w < ROW_WORDS; w++)
            pic[y][w * WORD_PX +: WORD_PX] = $urandom & $urandom & $urandom;
      end else begin
        draw_lane($urandom_range(1, 3), $urandom_range(0, 40), $urandom_range(0, 30));
        if ($urandom_range(0, 3) == 0) pic[$urandom_range(TOP_ROW, IMG_H - 2)] = '1;
      end
      if (kind == 6) load_frame(FRAME_WORDS + $urandom_range(1, 12));
      else if (kind == 7 || kind == 8) load_frame($urandom_range(1, 48));
      else load_frame(FRAME_WORDS);
      n_frames++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    wr_addr = 0;
    gaps_on = 1'b0;
    quiet_cycles = 0;
    mismatches = 0;
    words_sent = 0;
    frames_sent = 0;
    rows_predicted = 0;
    rows_checked = 0;
    fills_seen = 0;
    end_hits_seen = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // the first frame must fill the whole store before any short frame
    test_lane_frame();
    test_word_extremes();
    test_blank_frame();
    test_end_hit();
    test_early_frame_end();
    test_overlong_frame();
    test_random_frames();
    start <= 1'b0;

    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("loaded %0d frames in %0d pixel word transfers, checked %0d row results",
             frames_sent, words_sent, rows_checked);
    $display("%0d rows fell back to the frame middle, %0d scans stopped on a white centre",
             fills_seen, end_hits_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
